>>> rtl/arwb_pkg.sv
// Shared types, constants and the millisecond-to-sample conversion for the window buffer.
package arwb_pkg;

  // Field widths fixed by the item formats
  localparam int SAMPLE_W   = 32;
  localparam int MS_W       = 12;
  localparam int IDX_W      = 14;
  localparam int COUNT_W    = 15;
  localparam int DEF_MS_W   = 11;
  localparam int CFG_DATA_W = 11;
  localparam int CFG_IDX_W  = 1;

  // Store geometry and audio rate
  localparam int CAPACITY_DEF = 16384;
  localparam int SAMPLE_RATE  = 16000;
  localparam int MS_PER_S     = 1000;
  localparam int MS_MAX       = (2 ** MS_W) - 1;

  localparam logic [DEF_MS_W-1:0] DEFAULT_MS_RESET = DEF_MS_W'(1000);

  // Conversion split into whole samples per ms and a fractional remainder
  localparam int RATE_WHOLE  = SAMPLE_RATE / MS_PER_S;
  localparam int RATE_FRAC   = SAMPLE_RATE % MS_PER_S;
  localparam int SAMPLES_W   = $clog2((SAMPLE_RATE * MS_MAX) / MS_PER_S + 1);
  localparam int FRAC_W      = MS_W + 10;
  localparam int RECIP_SHIFT = 32;
  localparam int RECIP_W     = 23;
  localparam longint unsigned MS_RECIP = (64'd1 << RECIP_SHIFT) / MS_PER_S;

  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_TAKE  = 2'd1,
    OP_READ  = 2'd2,
    OP_CLEAR = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    STATUS_OK          = 2'd0,
    STATUS_NOT_RUNNING = 2'd1,
    STATUS_RANGE       = 2'd2
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RUNNING    = 1'd0,
    REG_DEFAULT_MS = 1'd1
  } reg_idx_e;

  typedef struct packed {
    opcode_e               opcode;
    logic [SAMPLE_W-1:0]   sample_bits;
    logic [MS_W-1:0]       window_ms;
    logic [IDX_W-1:0]      element_index;
  } in_t;

  typedef struct packed {
    status_e               status;
    logic [SAMPLE_W-1:0]   sample_out;
    logic [COUNT_W-1:0]    window_count;
    logic                  activity;
  } out_t;

  // Samples for a window of ms milliseconds, floor(SAMPLE_RATE * ms / 1000).
  // The fractional part divides by a reciprocal with one correction step.
  function automatic logic [SAMPLES_W-1:0] ms_to_samples(input logic [MS_W-1:0] ms);
    logic [SAMPLES_W-1:0]        whole;
    logic [FRAC_W-1:0]           part;
    logic [FRAC_W+RECIP_W-1:0]   prod;
    logic [FRAC_W-1:0]           quot;
    logic [FRAC_W-1:0]           rem;
    whole = SAMPLES_W'(32'(ms) * 32'(RATE_WHOLE));
    part  = FRAC_W'(32'(ms) * 32'(RATE_FRAC));
    prod  = (FRAC_W+RECIP_W)'(part) * (FRAC_W+RECIP_W)'(MS_RECIP);
    quot  = FRAC_W'(prod >> RECIP_SHIFT);
    rem   = part - FRAC_W'(quot * FRAC_W'(MS_PER_S));
    if (rem >= FRAC_W'(MS_PER_S)) begin
      quot = quot + FRAC_W'(1);
    end
    return whole + SAMPLES_W'(quot);
  endfunction

endpackage

>>> rtl/audio_ring_window_buffer_unit.sv
// Top level of the audio ring window buffer: last-N sample store with window capture.
//
// One beat is accepted every clock cycle while the result register is free or being taken, and
// its result beat appears on the cycle after acceptance; the pace is set by the single sample
// RAM, which takes one write (push) or one read (window element) per beat, and by the one-deep
// result register. A push stores the sample whatever the running bit says; take-window and
// clear answer "not running" when capture is stopped. Reads return the live store, so pushes
// after a take-window may replace elements of the recorded window. The sample RAM has no reset
// and no clearing pass: an entry that was never pushed reads back as whatever the RAM holds.
module audio_ring_window_buffer_unit #(
  parameter int CAPACITY = arwb_pkg::CAPACITY_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [arwb_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [arwb_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  arwb_pkg::in_t                       in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output arwb_pkg::out_t                      out_data_o
);
  import arwb_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int NW = (SAMPLES_W > CW) ? SAMPLES_W : CW;
  localparam int LW = (CW > IDX_W) ? CW : IDX_W;
  localparam int SW = ((AW > IDX_W) ? AW : IDX_W) + 1;
  localparam int WW = (CW > COUNT_W) ? CW : COUNT_W;

  // Configuration
  logic                running_q;
  logic [DEF_MS_W-1:0] default_ms_q;

  // Ring state
  logic [AW-1:0] wp_q, wp_d;
  logic [CW-1:0] fill_q, fill_d;
  logic [AW-1:0] ws_q, ws_d;
  logic [CW-1:0] wl_q, wl_d;
  logic          act_q, act_d;

  // Result register
  logic          out_valid_q;
  status_e       status_q, status_d;
  logic [CW-1:0] count_q;
  logic          act_out_q;
  logic          rd_ok_q, rd_ok_d;

  // RAM control
  logic                ram_we, ram_re;
  logic [AW-1:0]       ram_raddr;
  logic [SAMPLE_W-1:0] ram_rdata;

  // Datapath helpers
  logic                 in_fire;
  logic [AW-1:0]        wp_next;
  logic [MS_W-1:0]      ms_eff;
  logic [SAMPLES_W-1:0] n_raw;
  logic [NW-1:0]        n_ext, fill_ext;
  logic [CW-1:0]        n_clamp;
  logic [CW:0]          start_sum;
  logic [CW:0]          start_wrap;
  logic [LW-1:0]        idx_ext, len_ext;
  logic                 idx_oob;
  logic [SW-1:0]        addr_sum;
  logic [SW-1:0]        addr_wrap;
  logic [WW-1:0]        count_ext;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q    <= 1'b0;
      default_ms_q <= DEFAULT_MS_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_RUNNING:    running_q    <= cfg_data_i[0];
        REG_DEFAULT_MS: default_ms_q <= cfg_data_i[DEF_MS_W-1:0];
        default:        ;
      endcase
    end
  end

  // Advance the write position with wrap
  assign wp_next = (wp_q == AW'(CAPACITY - 1)) ? '0 : wp_q + AW'(1);

  // Convert the requested window to samples and clamp it to the fill
  assign ms_eff   = (in_data_i.window_ms == '0) ? MS_W'(default_ms_q) : in_data_i.window_ms;
  assign n_raw    = ms_to_samples(ms_eff);
  assign n_ext    = NW'(n_raw);
  assign fill_ext = NW'(fill_q);
  assign n_clamp  = (n_ext > fill_ext) ? fill_q : n_ext[CW-1:0];

  // Window start, wrapped back into the ring
  assign start_sum  = (CW+1)'(wp_q) + (CW+1)'(CAPACITY) - (CW+1)'(n_clamp);
  assign start_wrap = (start_sum >= (CW+1)'(CAPACITY)) ?
                      start_sum - (CW+1)'(CAPACITY) : start_sum;

  // Element read address and range check
  assign idx_ext   = LW'(in_data_i.element_index);
  assign len_ext   = LW'(wl_q);
  assign idx_oob   = (idx_ext >= len_ext);
  assign addr_sum  = SW'(ws_q) + SW'(in_data_i.element_index);
  assign addr_wrap = (addr_sum >= SW'(CAPACITY)) ? addr_sum - SW'(CAPACITY) : addr_sum;
  assign ram_raddr = addr_wrap[AW-1:0];

  // Next state for one accepted beat
  always_comb begin
    wp_d     = wp_q;
    fill_d   = fill_q;
    ws_d     = ws_q;
    wl_d     = wl_q;
    act_d    = act_q;
    status_d = STATUS_OK;
    rd_ok_d  = 1'b0;
    ram_we   = 1'b0;
    ram_re   = 1'b0;
    if (in_fire) begin
      case (in_data_i.opcode)
        OP_PUSH: begin
          ram_we = 1'b1;
          wp_d   = wp_next;
          if (fill_q < CW'(CAPACITY)) begin
            fill_d = fill_q + CW'(1);
          end
          act_d  = 1'b1;
        end
        OP_TAKE: begin
          act_d = 1'b0;
          if (!running_q) begin
            status_d = STATUS_NOT_RUNNING;
          end else begin
            wl_d = n_clamp;
            ws_d = start_wrap[AW-1:0];
          end
        end
        OP_READ: begin
          if (idx_oob) begin
            status_d = STATUS_RANGE;
          end else begin
            ram_re  = 1'b1;
            rd_ok_d = 1'b1;
          end
        end
        OP_CLEAR: begin
          if (!running_q) begin
            status_d = STATUS_NOT_RUNNING;
          end else begin
            wp_d   = '0;
            fill_d = '0;
          end
        end
        default: ;
      endcase
    end
  end

  // Ring state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q   <= '0;
      fill_q <= '0;
      ws_q   <= '0;
      wl_q   <= '0;
      act_q  <= 1'b0;
    end else begin
      wp_q   <= wp_d;
      fill_q <= fill_d;
      ws_q   <= ws_d;
      wl_q   <= wl_d;
      act_q  <= act_d;
    end
  end

  // Result beat: load on accept, drop once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      status_q  <= status_d;
      count_q   <= wl_d;
      act_out_q <= act_d;
      rd_ok_q   <= rd_ok_d;
    end
  end

  // Sample store
  arwb_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wp_q),
    .wdata_i (in_data_i.sample_bits),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Assemble the result payload
  assign count_ext = WW'(count_q);

  always_comb begin
    out_data_o.status       = status_q;
    out_data_o.sample_out   = rd_ok_q ? ram_rdata : '0;
    out_data_o.window_count = count_ext[COUNT_W-1:0];
    out_data_o.activity     = act_out_q;
  end

  assign out_valid_o = out_valid_q;

endmodule

>>> rtl/arwb_ram.sv
// Generic single-write, single-read RAM with registered read data.
module arwb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16384
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, hold data between reads
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
